// ===== design/awarm_pkg.sv =====
`default_nettype none
package awarm_pkg;
    localparam int Channels = 9;
    localparam int Rails = 4;
    localparam int Currents = 5;
    localparam int SampleW = 12;
    localparam int ChanW = 4;
    localparam int MvW = 15;
    localparam int WindowDepthDefault = 8;
    localparam logic [SampleW-1:0] OffsetReset = 12'd2703;
    localparam int CfgIdxW = 3;

    typedef struct packed {
        logic [ChanW-1:0]   channel_index;
        logic [SampleW-1:0] average_raw;
        logic [MvW-1:0]     rail_millivolts;
        logic signed [MvW-1:0] current_milliamps;
        logic               last_of_scan;
    } t_result;

    // floor(raw*2500/4096), max 2499
    function automatic logic [11:0] raw_to_mv(input logic [SampleW-1:0] raw);
        logic [23:0] p;
        p = raw * 24'd2500;
        return p[23:12];
    endfunction
endpackage
`default_nettype wire

// ===== design/adc_window_average_rail_monitor.sv =====
`default_nettype none
// After a scan is accepted, the lanes sweep the filled ring slots to form the sums; then
// each channel in turn is issued, divided by the shared bit-serial divider, scaled and
// registered at the output, where it waits for m_axis_tready. A new scan is accepted only
// in idle, after the last channel's result has been taken. Reset (sync, active low) clears
// ring position, fill count and offsets (to 2703); ring not cleared.
module adc_window_average_rail_monitor #(
    parameter int WINDOW_DEPTH = awarm_pkg::WindowDepthDefault
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // v24,v12,v5,v3v3,lcd,backlight,scaler,audio_l,audio_r (12b each, lowest first)
    input  wire [111:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // channel_index[3:0], average_raw[15:4], rail_millivolts[30:16],
    // current_milliamps[45:31], zero pad
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast,   // last_of_scan
    input  wire         i_cfg_we,
    input  wire [awarm_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  wire [awarm_pkg::SampleW-1:0] i_cfg_data
);
    import awarm_pkg::*;
    localparam int PosW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FillW = $clog2(WINDOW_DEPTH + 1);
    localparam int SumW = SampleW + FillW;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_SUM = 5'b00010, S_ISSUE = 5'b00100,
        S_WAIT = 5'b01000, S_OUT = 5'b10000
    } t_state;

    t_state r_state;
    logic [SampleW-1:0] r_off [Currents];
    logic [PosW-1:0]  r_wpos;
    logic [FillW-1:0] r_fill;
    logic [FillW:0]   r_rcnt;   // read sweep count; runs past the last slot since read data is registered
    logic [ChanW-1:0] r_chan;
    logic             r_clr;
    logic [SumW-1:0]  sums [Channels];
    logic             accept;
    logic             m_busy, m_done;
    t_result          m_res;
    logic [SampleW-1:0] cur_off;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    // Config writes; index beyond the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < Currents; k++) r_off[k] <= OffsetReset;
        end else if (i_cfg_we && (i_cfg_idx < CfgIdxW'(Currents))) begin
            r_off[i_cfg_idx] <= i_cfg_data;
        end
    end

    genvar g;
    generate
        for (g = 0; g < Channels; g++) begin : g_lane
            awarm_lane #(.WINDOW_DEPTH(WINDOW_DEPTH), .PosW(PosW), .SumW(SumW)) u_lane (
                .i_clk    (i_clk),
                .i_wr     (accept),
                .i_wr_pos (r_wpos),
                .i_wr_data(s_axis_tdata[g*SampleW +: SampleW]),
                .i_clr    (r_clr),
                .i_acc    ((r_state == S_SUM) && (r_rcnt != '0)),
                .i_rd_pos (r_rcnt[PosW-1:0]),
                .o_sum    (sums[g])
            );
        end
    endgenerate

    assign cur_off = (r_chan >= ChanW'(Rails)) ? r_off[3'(r_chan - ChanW'(Rails))] : '0;

    awarm_merge #(.SumW(SumW), .FillW(FillW)) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_ISSUE),
        .i_sum   (sums[r_chan]),
        .i_fill  (r_fill),
        .i_chan  (r_chan),
        .i_offset(cur_off),
        .o_busy  (m_busy),
        .o_done  (m_done),
        .o_res   (m_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wpos <= '0;
            r_fill <= '0;
            r_rcnt <= '0;
            r_chan <= '0;
            r_clr <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            // clear the lane sums right after a scan is taken
            r_clr <= accept;
            case (r_state)
                S_IDLE: if (accept) begin
                    // advance ring slot and fill count, then sweep the slots
                    r_wpos <= (r_wpos == PosW'(WINDOW_DEPTH - 1)) ? '0 : r_wpos + 1'b1;
                    if (r_fill != FillW'(WINDOW_DEPTH)) r_fill <= r_fill + 1'b1;
                    r_rcnt <= '0;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    // read data is registered, arriving in the cycle after its address
                    if (r_rcnt == {1'b0, r_fill}) begin
                        r_chan <= '0;
                        r_state <= S_ISSUE;
                    end else begin
                        r_rcnt <= r_rcnt + 1'b1;
                    end
                end
                S_ISSUE: r_state <= S_WAIT;
                S_WAIT: if (m_done) begin
                    m_axis_tvalid <= 1'b1;
                    m_axis_tdata <= {2'b00, m_res.current_milliamps, m_res.rail_millivolts,
                                     m_res.average_raw, m_res.channel_index};
                    m_axis_tlast <= m_res.last_of_scan;
                    r_state <= S_OUT;
                end
                S_OUT: if (m_axis_tready) begin
                    m_axis_tvalid <= 1'b0;
                    if (r_chan == ChanW'(Channels - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_chan <= r_chan + 1'b1;
                        r_state <= S_ISSUE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) && !m_done |-> m_busy) else $error("merge idle while waiting");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FillW'(WINDOW_DEPTH)) else $error("fill count overflow");
    a_tlast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> r_chan == ChanW'(Channels - 1))
        else $error("tlast on wrong channel");
endmodule
`default_nettype wire

// ===== design/awarm_lane.sv =====
`default_nettype none
// One channel: ring memory, running sum over the held slots.
module awarm_lane #(
    parameter int WINDOW_DEPTH = awarm_pkg::WindowDepthDefault,
    parameter int PosW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
    parameter int SumW = awarm_pkg::SampleW + $clog2(WINDOW_DEPTH + 1)
) (
    input  wire                          i_clk,
    input  wire                          i_wr,
    input  wire [PosW-1:0]               i_wr_pos,
    input  wire [awarm_pkg::SampleW-1:0] i_wr_data,
    input  wire                          i_clr,
    input  wire                          i_acc,
    input  wire [PosW-1:0]               i_rd_pos,
    output logic [SumW-1:0]              o_sum
);
    import awarm_pkg::*;
    logic [SampleW-1:0] r_mem [WINDOW_DEPTH];
    logic [SampleW-1:0] r_rd;
    logic [SumW-1:0]    r_sum;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[i_wr_pos] <= i_wr_data;
        end
        r_rd <= r_mem[i_rd_pos];
        if (i_clr) begin
            r_sum <= '0;
        end else if (i_acc) begin
            r_sum <= r_sum + SumW'(r_rd);
        end
    end
    assign o_sum = r_sum;
endmodule
`default_nettype wire

// ===== design/awarm_merge.sv =====
`default_nettype none
// Serial divider and scaler: one channel at a time.
module awarm_merge #(
    parameter int SumW = 16,
    parameter int FillW = 4
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wire [SumW-1:0]       i_sum,
    input  wire [FillW-1:0]      i_fill,
    input  wire [awarm_pkg::ChanW-1:0]   i_chan,
    input  wire [awarm_pkg::SampleW-1:0] i_offset,
    output logic                 o_busy,
    output logic                 o_done,
    output awarm_pkg::t_result   o_res
);
    import awarm_pkg::*;
    localparam int CntW = $clog2(SumW + 1);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_DIV = 4'b0010, S_MUL = 4'b0100, S_FIN = 4'b1000
    } t_state;
    t_state r_state;
    logic [SumW-1:0]  r_q;
    logic [FillW:0]   r_rem;
    logic [CntW-1:0]  r_cnt;
    logic [ChanW-1:0] r_chan;
    logic [SampleW-1:0] r_off;
    logic [24:0] r_prod;
    logic signed [24:0] r_iprod;
    logic [FillW-1:0] r_fill;
    logic [FillW:0] n_rem;
    logic [SampleW-1:0] avg;
    logic signed [12:0] diff;
    logic [24:0] mag;
    logic [50:0] rail_prod;
    logic [44:0] amp_prod;
    logic [15:0] q264;
    logic signed [MvW-1:0] amps;

    assign n_rem = {r_rem[FillW-1:0], r_q[SumW-1]};
    assign avg = r_q[SampleW-1:0];
    assign diff = $signed({1'b0, raw_to_mv(avg)}) - $signed({1'b0, raw_to_mv(r_off)});
    assign mag = r_iprod[24] ? 25'(-r_iprod) : 25'(r_iprod);
    // divide by 264 and by 1000 through reciprocals, exact over the product ranges
    assign amp_prod = 45'(mag[21:0]) * 45'd8134408;
    assign q264 = {2'b00, amp_prod[44:31]};
    assign rail_prod = 51'(r_prod) * 51'd34359739;
    assign amps = r_iprod[24] ? -$signed({1'b0, q264[MvW-2:0]})
                              : $signed({1'b0, q264[MvW-2:0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done <= 1'b0;
        end else begin
            o_done <= (r_state == S_FIN);
            case (r_state)
                S_IDLE: if (i_start) begin
                    r_state <= S_DIV;
                    r_q <= i_sum;
                    r_rem <= '0;
                    r_cnt <= CntW'(SumW);
                    r_chan <= i_chan;
                    r_off <= i_offset;
                    r_fill <= i_fill;
                end
                S_DIV: begin
                    // restoring division, one bit per cycle
                    if (n_rem >= {1'b0, r_fill}) begin
                        r_rem <= n_rem - {1'b0, r_fill};
                        r_q <= {r_q[SumW-2:0], 1'b1};
                    end else begin
                        r_rem <= n_rem;
                        r_q <= {r_q[SumW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CntW'(1)) r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod <= 25'(raw_to_mv(avg)) * 25'd11616;
                    r_iprod <= 25'(diff) * 25'sd1000;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    o_res.channel_index <= r_chan;
                    o_res.average_raw <= avg;
                    o_res.last_of_scan <= (r_chan == ChanW'(Channels - 1));
                    if (r_chan < ChanW'(Rails)) begin
                        o_res.rail_millivolts <= rail_prod[35 +: MvW];
                        o_res.current_milliamps <= '0;
                    end else begin
                        o_res.rail_millivolts <= '0;
                        o_res.current_milliamps <= amps;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
    assign o_busy = (r_state != S_IDLE);
endmodule
`default_nettype wire

// ===== sim/adc_window_average_rail_monitor_test.sv =====
`default_nettype none
module adc_window_average_rail_monitor_test;
    import awarm_pkg::*;

    localparam int WindowDepth = 8;
    localparam int RandomScans = 84;
    localparam int LongHoldCycles = 400;

    // register indexes of the current offset bank
    localparam logic [CfgIdxW-1:0] RegOffsetLcd = 3'd0;
    localparam logic [CfgIdxW-1:0] RegOffsetBacklight = 3'd1;
    localparam logic [CfgIdxW-1:0] RegOffsetScaler = 3'd2;
    localparam logic [CfgIdxW-1:0] RegOffsetAudioL = 3'd3;
    localparam logic [CfgIdxW-1:0] RegOffsetAudioR = 3'd4;
    localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

    typedef logic [SampleW-1:0] t_scan [Channels];

    // directed scan table; a nonzero check_avg means every channel's average
    // must equal avg_value (readable directly off the window contents)
    typedef struct {
        logic [SampleW-1:0] fill;
        bit                 alternate;
        bit                 check_avg;
        logic [SampleW-1:0] avg_value;
    } t_directed_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [47:0]  m_axis_tdata;
    logic         m_axis_tlast;
    logic         i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_idx = '0;
    logic [SampleW-1:0] i_cfg_data = '0;

    adc_window_average_rail_monitor #(.WINDOW_DEPTH(WindowDepth)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor copy of the block state
    logic [SampleW-1:0] window_samples [Channels][WindowDepth];
    int                 ring_slot;
    int                 ring_fill;
    logic [SampleW-1:0] current_offsets [Currents];

    t_result pending_results [$];
    int      error_count = 0;
    int      results_seen = 0;
    int      scans_sent = 0;
    bit      hold_off_sink = 1'b0;
    bit      sink_paused_long = 1'b0;

    function automatic logic [11:0] code_to_mv(input logic [SampleW-1:0] code);
        int unsigned prod;
        prod = code * 2500;
        return 12'(prod / 4096);
    endfunction

    // push the scan into the ring and queue the nine channel results
    task automatic predict_scan(input t_scan scan);
        int unsigned sum;
        int unsigned avg;
        int          diff;
        t_result     r;
        for (int ch = 0; ch < Channels; ch++) window_samples[ch][ring_slot] = scan[ch];
        ring_slot = (ring_slot + 1) % WindowDepth;
        if (ring_fill < WindowDepth) ring_fill++;
        for (int ch = 0; ch < Channels; ch++) begin
            sum = 0;
            for (int s = 0; s < ring_fill; s++) sum += window_samples[ch][s];
            avg = sum / ring_fill;
            r = '0;
            r.channel_index = ChanW'(ch);
            r.average_raw = SampleW'(avg);
            if (ch < Rails) begin
                r.rail_millivolts = MvW'((code_to_mv(SampleW'(avg)) * 11616) / 1000);
            end else begin
                // SV signed division truncates toward zero, as required
                diff = int'(code_to_mv(SampleW'(avg)))
                     - int'(code_to_mv(current_offsets[ch - Rails]));
                r.current_milliamps = MvW'((diff * 1000) / 264);
            end
            r.last_of_scan = (ch == Channels - 1);
            pending_results.push_back(r);
        end
    endtask

    task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                  input logic [SampleW-1:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx < Currents) current_offsets[idx] = value;
    endtask

    // wait for the pipeline to drain before touching registers
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    // entered and left at a falling edge; valid stays up when the next gap is zero
    task automatic send_scan(input t_scan scan, input int gap);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        for (int ch = 0; ch < Channels; ch++) s_axis_tdata[ch*SampleW +: SampleW] <= scan[ch];
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_scan(scan);
        scans_sent++;
        @(negedge i_clk);
    endtask

    function automatic t_scan random_scan();
        t_scan scan;
        int    style;
        style = $urandom_range(0, 9);
        for (int ch = 0; ch < Channels; ch++) begin
            case (style)
                0: scan[ch] = 12'hFFF;
                1: scan[ch] = 12'h000;
                2: scan[ch] = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
                default: scan[ch] = SampleW'($urandom);
            endcase
        end
        return scan;
    endfunction

    task automatic write_random_offsets();
        write_register(RegOffsetLcd, SampleW'($urandom));
        write_register(RegOffsetBacklight, SampleW'($urandom));
        write_register(RegOffsetScaler, SampleW'($urandom));
        write_register(RegOffsetAudioL, SampleW'($urandom));
        write_register(RegOffsetAudioR, SampleW'($urandom));
    endtask

    // receiver: random stall per transaction, long hold when requested
    initial begin
        t_result got;
        t_result want;
        int      stall;
        forever begin
            @(negedge i_clk);
            if (hold_off_sink) begin
                m_axis_tready <= 1'b0;
                repeat (LongHoldCycles) @(negedge i_clk);
                hold_off_sink = 1'b0;
                sink_paused_long = 1'b1;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            got = '0;
            got.channel_index = m_axis_tdata[3:0];
            got.average_raw = m_axis_tdata[15:4];
            got.rail_millivolts = m_axis_tdata[30:16];
            got.current_milliamps = m_axis_tdata[45:31];
            got.last_of_scan = m_axis_tlast;
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction, channel %0d", got.channel_index);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.channel_index !== want.channel_index) begin
                    $error("channel_index exp %0d got %0d",
                           want.channel_index, got.channel_index);
                    error_count++;
                end
                if (got.average_raw !== want.average_raw) begin
                    $error("average_raw exp %0d got %0d",
                           want.average_raw, got.average_raw);
                    error_count++;
                end
                if (got.rail_millivolts !== want.rail_millivolts) begin
                    $error("rail_millivolts exp %0d got %0d",
                           want.rail_millivolts, got.rail_millivolts);
                    error_count++;
                end
                if (got.current_milliamps !== want.current_milliamps) begin
                    $error("current_milliamps exp %0d got %0d",
                           want.current_milliamps, got.current_milliamps);
                    error_count++;
                end
                if (got.last_of_scan !== want.last_of_scan) begin
                    $error("last_of_scan exp %0d got %0d",
                           want.last_of_scan, got.last_of_scan);
                    error_count++;
                end
            end
        end
    end

    t_directed_row directed [16] = '{
        '{12'h000, 1'b0, 1'b1, 12'h000},
        '{12'hFFF, 1'b0, 1'b1, 12'h7FF},   // floor(4095/2)
        '{12'hFFF, 1'b0, 1'b1, 12'hAAA},
        '{12'hFFF, 1'b0, 1'b1, 12'hBFF},
        '{12'hA8F, 1'b0, 1'b0, 12'h000},   // offset level sample
        '{12'h555, 1'b1, 1'b0, 12'h000},
        '{12'hAAA, 1'b1, 1'b0, 12'h000},
        '{12'h001, 1'b0, 1'b0, 12'h000},
        '{12'hFFF, 1'b0, 1'b0, 12'h000},   // ring wraps here
        '{12'hFFF, 1'b0, 1'b0, 12'h000},
        '{12'hFFF, 1'b0, 1'b0, 12'h000},
        '{12'hFFF, 1'b0, 1'b0, 12'h000},
        '{12'hFFF, 1'b0, 1'b0, 12'h000},
        '{12'hFFF, 1'b0, 1'b0, 12'h000},
        '{12'hFFF, 1'b0, 1'b0, 12'h000},
        '{12'hFFF, 1'b0, 1'b1, 12'hFFF}    // window entirely full scale
    };

    // stimulus
    initial begin
        t_scan scan;
        for (int i = 0; i < Currents; i++) current_offsets[i] = OffsetReset;
        ring_slot = 0;
        ring_fill = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk, default offsets
        foreach (directed[row]) begin
            for (int ch = 0; ch < Channels; ch++)
                scan[ch] = (directed[row].alternate && ch[0]) ? ~directed[row].fill
                                                              : directed[row].fill;
            send_scan(scan, $urandom_range(0, 19));
            if (directed[row].check_avg)
                for (int k = pending_results.size() - Channels; k < pending_results.size(); k++)
                    if (pending_results[k].average_raw !== directed[row].avg_value) begin
                        $error("average_raw exp %0d got %0d (window model)",
                               directed[row].avg_value, pending_results[k].average_raw);
                        error_count++;
                    end
        end
        wait_drained();

        // offset extremes, plus a write to an unused index that must be ignored
        write_register(RegOffsetLcd, 12'h000);
        write_register(RegOffsetBacklight, 12'hFFF);
        write_register(RegOffsetScaler, 12'h000);
        write_register(RegOffsetAudioL, 12'hFFF);
        write_register(RegOffsetAudioR, 12'h800);
        write_register(RegUnused, 12'h123);
        for (int n = 0; n < 4; n++) begin
            for (int ch = 0; ch < Channels; ch++) scan[ch] = n[0] ? 12'hFFF : 12'h000;
            send_scan(scan, $urandom_range(0, 19));
        end

        // receiver holds off while the sender keeps offering scans
        hold_off_sink = 1'b1;
        for (int n = 0; n < 6; n++) send_scan(random_scan(), 0);
        wait_drained();

        // random phases with new offsets between them
        for (int phase = 0; phase < 4; phase++) begin
            write_random_offsets();
            for (int n = 0; n < RandomScans / 4; n++) begin
                send_scan(random_scan(), ($urandom_range(0, 4) == 0) ? 0
                                                                   : $urandom_range(0, 19));
                if (n == 10) begin
                    s_axis_tvalid <= 1'b0;
                    while (pending_results.size() != 0) @(negedge i_clk);
                end
            end
            wait_drained();
        end
        write_register(RegOffsetLcd, 12'hFFF);
        write_register(RegOffsetBacklight, 12'h000);
        for (int n = 0; n < 3; n++) send_scan(random_scan(), $urandom_range(0, 19));
        wait_drained();

        $display("covered %0d scans, %0d result transactions, offsets at both extremes,",
                 scans_sent, results_seen);
        $display("ring wrap, partial windows and a %0d-cycle output hold-off",
                 LongHoldCycles);
        if (error_count == 0 && pending_results.size() == 0 && sink_paused_long) begin
            $display("adc_window_average_rail_monitor verification clean");
        end else begin
            $display("adc_window_average_rail_monitor verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3000000;
        $display("adc_window_average_rail_monitor verification failed");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
design/awarm_pkg.sv
design/awarm_lane.sv
design/awarm_merge.sv
design/adc_window_average_rail_monitor.sv
sim/adc_window_average_rail_monitor_test.sv
